/* design/swlt_pkg.sv */
// Package for the sequence window loss tracker.
// Holds the shared widths, the configuration register indexes, the queue item type and the
// back-end state type. No dependencies.
package swlt_pkg;

  localparam int SEQ_W      = 32;
  localparam int RUN_W      = 32;
  localparam int LEN_W      = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 32;

  localparam logic [RUN_W-1:0] ACTIVE_RUN_RST = RUN_W'(1);

  typedef enum logic [0:0] {
    CFG_ENABLE     = 1'b0,
    CFG_ACTIVE_RUN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             acc;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADV,
    ST_FLUSH,
    ST_SKIP,
    ST_MARK,
    ST_DONE
  } back_state_t;

endpackage

/* design/swlt_ifs.sv */
// Channel interfaces of the sequence window loss tracker: the frame input and the result output.
// Depends on swlt_pkg.
interface swlt_in_if;
  import swlt_pkg::*;
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] frame_seq;
  logic [RUN_W-1:0] frame_run;
  logic             short_frame;
  logic [LEN_W-1:0] frame_len;

  modport source(output valid, frame_seq, frame_run, short_frame, frame_len, input ready);
  modport sink(input valid, frame_seq, frame_run, short_frame, frame_len, output ready);
endinterface

interface swlt_out_if;
  import swlt_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [CNT_W-1:0] total_frames;
  logic [CNT_W-1:0] lost_frames;
  logic [CNT_W-1:0] dup_frames;
  logic [CNT_W-1:0] reorder_frames;
  logic [CNT_W-1:0] rx_bytes;
  logic [SEQ_W-1:0] next_expected;

  modport source(output valid, accepted, total_frames, lost_frames, dup_frames, reorder_frames,
                 rx_bytes, next_expected, input ready);
  modport sink(input valid, accepted, total_frames, lost_frames, dup_frames, reorder_frames,
               rx_bytes, next_expected, output ready);
endinterface

/* design/swlt_front.sv */
// Front end: holds the configuration registers and decides for each frame whether it is counted.
// Depends on swlt_pkg and swlt_in_if.
module swlt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  swlt_pkg::cfg_idx_t             cfg_idx,
  input  logic [swlt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  swlt_in_if.sink                        in_ch,
  output logic                           push_valid,
  output swlt_pkg::item_t                push_item,
  input  logic                           push_ready
);
  import swlt_pkg::*;

  logic             enable_r;
  logic [RUN_W-1:0] active_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      active_run_r <= ACTIVE_RUN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ENABLE:     enable_r     <= cfg_wdata[0];
        CFG_ACTIVE_RUN: active_run_r <= cfg_wdata[RUN_W-1:0];
        default:        enable_r     <= enable_r;
      endcase
    end
  end

  assign in_ch.ready   = push_ready;
  assign push_valid    = in_ch.valid;
  assign push_item.acc = enable_r && (in_ch.short_frame || (in_ch.frame_run == active_run_r));
  assign push_item.seq = in_ch.frame_seq;
  assign push_item.len = in_ch.frame_len;

endmodule

/* design/swlt_fifo.sv */
// Two-entry queue of classified frames between the front end and the back end.
// Depends on swlt_pkg.
module swlt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  swlt_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output swlt_pkg::item_t pop_item,
  input  logic            pop_ready
);
  import swlt_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* design/swlt_back.sv */
// Back end: sequence window state, counters, result register and the step sequencer that
// moves the window one position a step or skips ahead. Depends on swlt_pkg and swlt_out_if.
module swlt_back #(
  parameter int WINDOW_BITS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  swlt_pkg::item_t pop_item,
  output logic            pop_ready,
  swlt_out_if.source      out_ch
);
  import swlt_pkg::*;

  localparam int IW = $clog2(WINDOW_BITS);
  localparam logic [SEQ_W-1:0] WIN_D  = SEQ_W'(WINDOW_BITS);
  localparam logic [SEQ_W-1:0] WIN_2D = SEQ_W'(2 * WINDOW_BITS);
  localparam logic [SEQ_W-1:0] WIN_M1 = SEQ_W'(WINDOW_BITS - 1);
  localparam logic [IW-1:0] FLUSH_LAST = IW'(WINDOW_BITS - 2);
  localparam logic [WINDOW_BITS-1:0] TOP_MARK = {2'b01, {(WINDOW_BITS - 2){1'b0}}};

  back_state_t            state_r, state_nxt;
  logic [SEQ_W-1:0]       seq_r, seq_nxt;
  logic                   acc_r, acc_nxt;
  logic                   adv_loop_r, adv_loop_nxt;
  logic [IW-1:0]          flush_cnt_r, flush_cnt_nxt;
  logic [SEQ_W-1:0]       skip_r, skip_nxt;
  logic [SEQ_W-1:0]       next_r, next_nxt;
  logic [WINDOW_BITS-1:0] win_r, win_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [CNT_W-1:0]       lost_r, lost_nxt;
  logic [CNT_W-1:0]       dup_r, dup_nxt;
  logic [CNT_W-1:0]       reorder_r, reorder_nxt;
  logic [CNT_W-1:0]       bytes_r, bytes_nxt;

  logic                   ov_r, ov_nxt;
  logic                   o_acc_r, o_acc_nxt;
  logic [CNT_W-1:0]       o_total_r, o_total_nxt;
  logic [CNT_W-1:0]       o_lost_r, o_lost_nxt;
  logic [CNT_W-1:0]       o_dup_r, o_dup_nxt;
  logic [CNT_W-1:0]       o_reorder_r, o_reorder_nxt;
  logic [CNT_W-1:0]       o_bytes_r, o_bytes_nxt;
  logic [SEQ_W-1:0]       o_next_r, o_next_nxt;

  logic [SEQ_W-1:0]       d_head;
  logic [SEQ_W-1:0]       d_cur;
  logic [IW-1:0]          bit_idx;
  logic [WINDOW_BITS-1:0] win_shift;

  assign d_head    = pop_item.seq - next_r;
  assign d_cur     = seq_r - next_r;
  assign bit_idx   = d_cur[IW-1:0] - IW'(1);
  assign win_shift = {1'b0, win_r[WINDOW_BITS-1:1]};

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    acc_nxt       = acc_r;
    adv_loop_nxt  = adv_loop_r;
    flush_cnt_nxt = flush_cnt_r;
    skip_nxt      = skip_r;
    next_nxt      = next_r;
    win_nxt       = win_r;
    total_nxt     = total_r;
    lost_nxt      = lost_r;
    dup_nxt       = dup_r;
    reorder_nxt   = reorder_r;
    bytes_nxt     = bytes_r;
    ov_nxt        = ov_r && !out_ch.ready;
    o_acc_nxt     = o_acc_r;
    o_total_nxt   = o_total_r;
    o_lost_nxt    = o_lost_r;
    o_dup_nxt     = o_dup_r;
    o_reorder_nxt = o_reorder_r;
    o_bytes_nxt   = o_bytes_r;
    o_next_nxt    = o_next_r;
    pop_ready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          pop_ready = 1'b1;
          seq_nxt   = pop_item.seq;
          acc_nxt   = pop_item.acc;
          state_nxt = ST_DONE;
          if (pop_item.acc) begin
            total_nxt = total_r + CNT_W'(1);
            bytes_nxt = bytes_r + CNT_W'(pop_item.len);
            if (d_head == '0) begin
              adv_loop_nxt = 1'b0;
              state_nxt    = ST_ADV;
            end else if (d_head[SEQ_W-1]) begin
              dup_nxt = dup_r + CNT_W'(1);
            end else if (d_head > WIN_2D) begin
              lost_nxt      = lost_r + CNT_W'(1);
              next_nxt      = next_r + SEQ_W'(1);
              flush_cnt_nxt = '0;
              state_nxt     = ST_FLUSH;
            end else begin
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (!d_cur[SEQ_W-1] && (d_cur >= WIN_D)) begin
          lost_nxt     = lost_r + CNT_W'(1);
          adv_loop_nxt = 1'b1;
          state_nxt    = ST_ADV;
        end else if (d_cur == '0) begin
          adv_loop_nxt = 1'b0;
          state_nxt    = ST_ADV;
        end else begin
          if (!d_cur[SEQ_W-1] && (d_cur <= WIN_M1)) begin
            if (win_r[bit_idx]) begin
              dup_nxt = dup_r + CNT_W'(1);
            end else begin
              win_nxt[bit_idx] = 1'b1;
              reorder_nxt      = reorder_r + CNT_W'(1);
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_ADV: begin
        next_nxt = next_r + SEQ_W'(1);
        win_nxt  = win_shift;
        if (!win_r[0]) begin
          state_nxt = adv_loop_r ? ST_CHECK : ST_DONE;
        end
      end
      ST_FLUSH: begin
        if (!win_r[0]) begin
          lost_nxt = lost_r + CNT_W'(1);
        end
        next_nxt      = next_r + SEQ_W'(1);
        win_nxt       = win_shift;
        flush_cnt_nxt = flush_cnt_r + IW'(1);
        if (flush_cnt_r == FLUSH_LAST) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        win_nxt   = '0;
        skip_nxt  = seq_r - next_r - WIN_M1;
        next_nxt  = seq_r - WIN_M1;
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        lost_nxt    = lost_r + skip_r;
        win_nxt     = TOP_MARK;
        reorder_nxt = reorder_r + CNT_W'(1);
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt        = 1'b1;
          o_acc_nxt     = acc_r;
          o_total_nxt   = total_r;
          o_lost_nxt    = lost_r;
          o_dup_nxt     = dup_r;
          o_reorder_nxt = reorder_r;
          o_bytes_nxt   = bytes_r;
          o_next_nxt    = next_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      next_r    <= '0;
      win_r     <= '0;
      total_r   <= '0;
      lost_r    <= '0;
      dup_r     <= '0;
      reorder_r <= '0;
      bytes_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      next_r    <= next_nxt;
      win_r     <= win_nxt;
      total_r   <= total_nxt;
      lost_r    <= lost_nxt;
      dup_r     <= dup_nxt;
      reorder_r <= reorder_nxt;
      bytes_r   <= bytes_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    acc_r       <= acc_nxt;
    adv_loop_r  <= adv_loop_nxt;
    flush_cnt_r <= flush_cnt_nxt;
    skip_r      <= skip_nxt;
    o_acc_r     <= o_acc_nxt;
    o_total_r   <= o_total_nxt;
    o_lost_r    <= o_lost_nxt;
    o_dup_r     <= o_dup_nxt;
    o_reorder_r <= o_reorder_nxt;
    o_bytes_r   <= o_bytes_nxt;
    o_next_r    <= o_next_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.accepted       = o_acc_r;
  assign out_ch.total_frames   = o_total_r;
  assign out_ch.lost_frames    = o_lost_r;
  assign out_ch.dup_frames     = o_dup_r;
  assign out_ch.reorder_frames = o_reorder_r;
  assign out_ch.rx_bytes       = o_bytes_r;
  assign out_ch.next_expected  = o_next_r;

endmodule

/* design/seq_window_loss_tracker_unit.sv */
// Channel   Direction  Handshake         Payload
// in_ch     sink       valid/ready       frame_seq, frame_run, short_frame, frame_len
// out_ch    source     valid/ready       accepted, counters, next_expected
// cfg_*     write      cfg_we            cfg_idx selects enable or active_run, cfg_wdata
//
// Dropped and duplicate frames go straight to the result step, in-window frames pass a
// check first and in-order frames advance past the run of marked bits they close. A gap of
// WINDOW_BITS to twice that alternates check and advance; a longer gap runs flush, skip, mark.
// Reset is synchronous and clears all counters, the window and the expected sequence number.
// A two-entry request queue lets the input keep accepting until it is full while the back end
// works or the result register waits for out_ch.ready.
module seq_window_loss_tracker_unit #(
  parameter int WINDOW_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  swlt_pkg::cfg_idx_t              cfg_idx,
  input  logic [swlt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  swlt_in_if.sink                         in_ch,
  swlt_out_if.source                      out_ch
);
  import swlt_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  swlt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_item (push_item),
    .push_ready(push_ready)
  );

  swlt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_item (push_item),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready)
  );

  swlt_back #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_item (pop_item),
    .pop_ready(pop_ready),
    .out_ch   (out_ch)
  );

endmodule
